// ----- sv/bec_pkg.sv -----
package bec_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_COLUMNS = 1'b0,
    CFG_LINE_LENGTH   = 1'b1
  } cfg_index_t;

  localparam int CFG_WIDTH         = 13;
  localparam int LINE_REG_WIDTH    = 11;
  localparam int COLUMNS_RESET     = 1024;
  localparam int LINE_RESET        = 1024;
  localparam int MIN_SIZE          = 3;
  localparam int BYTE_PAD          = 7;

  // Per-item information handed from the scan counters to the evaluation stage
  typedef struct packed {
    logic produce;   // item yields a result
    logic last;      // result closes the frame
    logic interior;  // output pixel is off the frame border
    logic below;     // pixel one line below the output pixel
    logic sel;       // line buffer that holds the line above the output pixel
  } scan_info_t;

endpackage

// ----- sv/bec_line_ram.sv -----
module bec_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] addr_a,
  input  logic [AW-1:0] addr_b,
  input  logic          wr_en,
  input  logic          wr_bit,
  output logic          rd_a,
  output logic          rd_b
);

  logic mem [DEPTH];

  // Read-first: a write to addr_a returns the old bit on rd_a
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
    if (wr_en) begin
      mem[addr_a] <= wr_bit;
    end
  end

endmodule

// ----- sv/bec_scan.sv -----
module bec_scan #(
  parameter int MAX_LINE    = 1024,
  parameter int MAX_COLUMNS = 4096,
  parameter int AW          = $clog2(MAX_LINE)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  bec_pkg::cfg_index_t           cfg_index,
  input  logic [bec_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                          accept,
  input  logic                          pixel_in,
  input  logic                          drain,
  output logic [AW-1:0]                 addr_a,
  output logic [AW-1:0]                 addr_b,
  output logic                          take,
  output bec_pkg::scan_info_t           info
);
  import bec_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RST_COLS = (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET;
  localparam int RST_LINE = (LINE_RESET > MAX_LINE) ? MAX_LINE : LINE_RESET;

  logic [CW-1:0] columns;
  logic [LW-1:0] line_len;
  logic [AW-1:0] row;
  logic [CW-1:0] col;
  logic          sel;

  logic [AW-1:0] row_next;
  logic          row_last;
  logic          complete;
  logic [LINE_REG_WIDTH-1:0] line_value;

  assign line_value = cfg_data[LINE_REG_WIDTH-1:0];

  always_comb begin
    row_last      = (LW'(row) == line_len - LW'(1));
    row_next      = row_last ? '0 : row + AW'(1);
    complete      = (col == columns);
    take          = accept && (complete || !drain);
    addr_a        = row;
    addr_b        = row_next;
    info.produce  = complete || (col != '0);
    info.last     = complete && row_last;
    info.interior = !complete && (col >= CW'(2)) && (row != '0) && !row_last;
    info.below    = !complete && pixel_in;
    info.sel      = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns  <= CW'(RST_COLS);
      line_len <= LW'(RST_LINE);
      row      <= '0;
      col      <= '0;
      sel      <= 1'b0;
    end else if (cfg_we) begin
      // Clamp into the supported range and restart the frame
      unique case (cfg_index)
        CFG_FRAME_COLUMNS: begin
          if (cfg_data < CFG_WIDTH'(MIN_SIZE)) begin
            columns <= CW'(MIN_SIZE);
          end else if (32'(cfg_data) > 32'(MAX_COLUMNS)) begin
            columns <= CW'(MAX_COLUMNS);
          end else begin
            columns <= CW'(cfg_data);
          end
        end
        CFG_LINE_LENGTH: begin
          if (line_value < LINE_REG_WIDTH'(MIN_SIZE)) begin
            line_len <= LW'(MIN_SIZE);
          end else if (32'(line_value) > 32'(MAX_LINE)) begin
            line_len <= LW'(MAX_LINE);
          end else begin
            line_len <= LW'(line_value);
          end
        end
        default: ;
      endcase
      row <= '0;
      col <= '0;
    end else if (take) begin
      row <= row_next;
      if (row_last) begin
        sel <= ~sel;
        col <= info.last ? '0 : col + CW'(1);
      end
    end
  end

endmodule

// ----- sv/bec_eval.sv -----
module bec_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                take,
  input  bec_pkg::scan_info_t info,
  input  logic                rd0_a,
  input  logic                rd0_b,
  input  logic                rd1_a,
  input  logic                rd1_b,
  input  logic                m_ready,
  output logic                s_ready,
  output logic                m_valid,
  output logic                pixel_out,
  output logic                frame_last,
  output logic                frame_changed
);
  import bec_pkg::*;

  scan_info_t s1;
  logic       s1_valid;
  logic       s1_adv;
  logic       left;
  logic       changed;
  logic       center;
  logic       right;
  logic       above;
  logic       keep;
  logic       removed;

  always_comb begin
    // s1.sel names the buffer holding the line above; the other holds the center line
    center  = s1.sel ? rd0_a : rd1_a;
    right   = s1.sel ? rd0_b : rd1_b;
    above   = s1.sel ? rd1_a : rd0_a;
    keep    = center && s1.interior && above && s1.below && left && right;
    removed = center && !keep;
    s1_adv  = s1_valid && (!m_valid || m_ready);
    s_ready = !s1_valid || !m_valid || m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_valid  <= 1'b0;
      changed  <= 1'b0;
    end else begin
      if (take && info.produce) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (restart) begin
        changed <= 1'b0;
      end else if (s1_adv) begin
        changed <= !s1.last && (changed || removed);
      end
    end
  end

  // Payload: advance into the output register, hold while stalled
  always_ff @(posedge clk) begin
    if (take && info.produce) begin
      s1 <= info;
    end
    if (s1_adv) begin
      left          <= center;
      pixel_out     <= keep;
      frame_last    <= s1.last;
      frame_changed <= s1.last && (changed || removed);
    end
  end

endmodule

// ----- sv/binary_erosion_cross_unit.sv -----
// Channel  | Handshake         | Payload
// s_*      | s_tvalid/s_tready | tdata[0] pixel_in, tuser drain
// m_*      | m_tvalid/m_tready | tdata[0] pixel_out, tlast frame_last, tuser frame_changed
// cfg_*    | cfg_we            | cfg_index register, cfg_data value
//
// One item per clock sustained while the output is not stalled; a result passes through
// the read stage, where the line RAMs are read, then the output register, one line behind the input.
// Two line RAMs of MAX_LINE bits swap roles each line; no clearing pass after reset,
// stale lines only feed border pixels.
// Synchronous active-high reset clears counters, valids and the changed flag.
// A stalled output holds one result in the output register and one in the read stage;
// input is refused only when both are full.
module binary_erosion_cross_unit #(
  parameter int MAX_LINE    = 1024,
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] pixel_in, [7:1] zero
  input  logic                          s_tuser,   // [0] drain
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [0] pixel_out, [7:1] zero
  output logic                          m_tlast,
  output logic                          m_tuser,   // [0] frame_changed
  input  logic                          cfg_we,
  input  bec_pkg::cfg_index_t           cfg_index,
  input  logic [bec_pkg::CFG_WIDTH-1:0] cfg_data
);
  import bec_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  logic          accept;
  logic          take;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  scan_info_t    info;
  logic          rd0_a;
  logic          rd0_b;
  logic          rd1_a;
  logic          rd1_b;
  logic          pixel_out;

  assign accept  = s_tvalid && s_tready;
  assign m_tdata = {{BYTE_PAD{1'b0}}, pixel_out};

  // Position counters, config registers and per-item flags
  bec_scan #(
    .MAX_LINE    (MAX_LINE),
    .MAX_COLUMNS (MAX_COLUMNS),
    .AW          (AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel_in  (s_tdata[0]),
    .drain     (s_tuser),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .take      (take),
    .info      (info)
  );

  // Buffer 0 takes the new line when sel is low, buffer 1 when sel is high;
  // the incoming pixel overwrites the line above at the same address.
  bec_line_ram #(
    .DEPTH (MAX_LINE),
    .AW    (AW)
  ) u_ram0 (
    .clk    (clk),
    .rd_en  (accept),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .wr_en  (take && !info.sel),
    .wr_bit (info.below),
    .rd_a   (rd0_a),
    .rd_b   (rd0_b)
  );

  bec_line_ram #(
    .DEPTH (MAX_LINE),
    .AW    (AW)
  ) u_ram1 (
    .clk    (clk),
    .rd_en  (accept),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .wr_en  (take && info.sel),
    .wr_bit (info.below),
    .rd_a   (rd1_a),
    .rd_b   (rd1_b)
  );

  // Kernel, changed flag and output register
  bec_eval u_eval (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .take          (take),
    .info          (info),
    .rd0_a         (rd0_a),
    .rd0_b         (rd0_b),
    .rd1_a         (rd1_a),
    .rd1_b         (rd1_b),
    .m_ready       (m_tready),
    .s_ready       (s_tready),
    .m_valid       (m_tvalid),
    .pixel_out     (pixel_out),
    .frame_last    (m_tlast),
    .frame_changed (m_tuser)
  );

  // The changed flag is only reported on the frame's final result
  a_changed_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_changed without frame_last");

  // The final pixel sits on the border and always comes out black
  a_last_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[0])
    else $error("final pixel kept white");

  // Input is refused only while a result is waiting on a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused with output free");

endmodule

// ----- tb/binary_erosion_cross_unit_test.sv -----
module binary_erosion_cross_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bec_pkg::*;

  // Sizes of the instance under test
  localparam int LINE_STORE     = 1024;
  localparam int COLUMN_LIMIT   = 4096;
  // Stimulus and run control
  localparam int RANDOM_ITEMS   = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int REPORT_LIMIT   = 10;

  // One expected result: eroded pixel, end of frame, frame changed
  typedef struct packed {
    logic pixel;
    logic last;
    logic changed;
  } erosion_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;   // [0] pixel_in, [7:1] zero
  logic                 s_tuser = 1'b0;    // [0] drain
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;           // [0] pixel_out, [7:1] zero
  logic                 m_tlast;
  logic                 m_tuser;           // [0] frame_changed
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = CFG_FRAME_COLUMNS;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  binary_erosion_cross_unit #(
    .MAX_LINE   (LINE_STORE),
    .MAX_COLUMNS(COLUMN_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Erosion predictor: register copies, pixel history and scan counters
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0]      reg_columns;   // lines per frame, raw register value
  logic [LINE_REG_WIDTH-1:0] reg_line;      // pixels per line, raw register value
  bit                        pix_hist [0:2*LINE_STORE];
  int unsigned               in_col, in_row, out_col, out_row;
  bit                        frame_dirty;   // a white pixel was removed this frame
  bit                        input_done;    // all pixels of the frame are in

  erosion_result_t eroded_q[$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int frames_seen     = 0;
  int items_counted   = 0;

  // Knobs shared by the test tasks and the receiver; a new hold-off is
  // requested by bumping hold_serial
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int hold_length = 0;
  int hold_serial = 0;

  // Effective sizes after clamping the registers to the supported range
  function automatic int unsigned line_len();
    if (reg_line < MIN_SIZE) return MIN_SIZE;
    if (reg_line > LINE_STORE) return LINE_STORE;
    return 32'(reg_line);
  endfunction

  function automatic int unsigned line_count();
    if (reg_columns < MIN_SIZE) return MIN_SIZE;
    if (reg_columns > COLUMN_LIMIT) return COLUMN_LIMIT;
    return 32'(reg_columns);
  endfunction

  function automatic void frame_restart();
    foreach (pix_hist[i]) pix_hist[i] = 1'b0;
    in_col      = 0;
    in_row      = 0;
    out_col     = 0;
    out_row     = 0;
    frame_dirty = 1'b0;
    input_done  = 1'b0;
  endfunction

  // Any register write restarts the frame
  function automatic void apply_register(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] val);
    case (idx)
      CFG_FRAME_COLUMNS: reg_columns = val;
      CFG_LINE_LENGTH:   reg_line = val[LINE_REG_WIDTH-1:0];
      default: ;
    endcase
    frame_restart();
  endfunction

  // Advance the predictor by one accepted item; push the result it causes.
  // Return 0 when the block ignores the item (drain before the frame is in).
  function automatic bit erode_step(input logic px, input logic drn);
    int unsigned l, c, i;
    bit was_done, produce, center, interior, keep, removed, last;
    erosion_result_t res;
    l = line_len();
    c = line_count();
    was_done = input_done;
    if (!was_done && drn) return 1'b0;
    // Shift the pixel in; once the frame is complete every item shifts black
    for (i = 2 * l; i > 0; i--) pix_hist[i] = pix_hist[i-1];
    pix_hist[0] = was_done ? 1'b0 : px;
    if (!was_done) begin
      produce = in_col >= 1;
      in_row++;
      if (in_row >= l) begin
        in_row = 0;
        in_col++;
        if (in_col >= c) begin
          in_col     = 0;
          input_done = 1'b1;
        end
      end
      if (!produce) return 1'b1;
    end
    // Output pixel sits one line back; neighbours are one pixel and one line away
    center   = pix_hist[l];
    interior = out_col > 0 && out_col < c - 1 && out_row > 0 && out_row < l - 1;
    keep     = center && interior && pix_hist[0] && pix_hist[2*l] &&
               pix_hist[l-1] && pix_hist[l+1];
    removed  = center && !keep;
    last     = out_col == c - 1 && out_row == l - 1;
    res.pixel   = keep;
    res.last    = last;
    res.changed = last && (frame_dirty || removed);
    eroded_q.push_back(res);
    if (removed) frame_dirty = 1'b1;
    if (last) begin
      frame_restart();
    end else begin
      out_row++;
      if (out_row >= l) begin
        out_row = 0;
        out_col++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: check each result, then draw the stall before the next one
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0t] result %0d: %s", $realtime,
                                                 results_checked, what);
  endtask

  int rx_wait   = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    erosion_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (eroded_q.size() == 0) begin
        report_mismatch($sformatf("none expected, got tdata %h tlast %b tuser %b",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = eroded_q.pop_front();
        if (m_tdata !== {7'b0, want.pixel} || m_tlast !== want.last ||
            m_tuser !== want.changed) begin
          report_mismatch($sformatf(
            "expected pixel %b last %b changed %b, got tdata %h tlast %b tuser %b",
            want.pixel, want.last, want.changed, m_tdata, m_tlast, m_tuser));
        end
        if (want.last) frames_seen++;
      end
      results_checked++;
      rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
    end
    // Pick up a long hold-off request and count it down here
    if (hold_serial != hold_seen) begin
      hold_left = hold_length;
      hold_seen = hold_serial;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, eroded_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers; all are entered and left at a rising edge
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap, hold it until accepted, then predict.
  // Keep tvalid high across back-to-back items; drop it only for a gap.
  task automatic send_item(input logic px, input logic drn);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, px};
    s_tuser  <= drn;
    do @(posedge clk); while (!s_tready);
    if (erode_step(px, drn)) items_counted++;
  endtask

  // Drop tvalid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (eroded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the predictor follows at the same edge
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
    @(posedge clk);
  endtask

  // Send one frame from its first pixel: pixels with stray drains mixed in,
  // then a line of drain items, a quarter of them carrying a pixel instead.
  // When abandoned, stop somewhere inside the pixel part.
  task automatic send_frame(input int density, input bit abandon);
    int unsigned l, total, stop_at, k;
    l       = line_len();
    total   = l * line_count();
    stop_at = abandon ? $urandom_range(1, total - 1) : total;
    for (k = 0; k < stop_at; k++) begin
      if ($urandom_range(0, 19) == 0) send_item(1'($urandom_range(0, 1)), 1'b1);
      send_item($urandom_range(0, 99) < density, 1'b0);
    end
    if (!abandon) begin
      for (k = 0; k < l; k++) begin
        send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Smallest frame, sizes written below range, all-white and all-black content
  task automatic test_directed();
    int k;
    write_reg(CFG_FRAME_COLUMNS, '0);
    write_reg(CFG_LINE_LENGTH, CFG_WIDTH'(1));
    // Drain before any pixel: ignored
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);
    // All white: only the center survives, frame reports a change
    for (k = 0; k < 9; k++) begin
      send_item(1'b1, 1'b0);
      if (k == 4) send_item(1'b0, 1'b1);
    end
    // Drain phase, with a pixel item standing in for a drain
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    // All black: no change reported
    for (k = 0; k < 9; k++) send_item(1'b0, 1'b0);
    for (k = 0; k < 3; k++) send_item(1'b1, 1'b1);
    settle();
  endtask

  // Longest line (all-ones write clamps to the line store), shortest frame;
  // stop a few pixels into the second line
  task automatic test_largest_line();
    int k;
    write_reg(CFG_LINE_LENGTH, '1);
    write_reg(CFG_FRAME_COLUMNS, CFG_WIDTH'(MIN_SIZE));
    for (k = 0; k < LINE_STORE + 8; k++) send_item($urandom_range(0, 99) < 95, 1'b0);
    settle();
  endtask

  // Most lines per frame (all-ones write clamps), shortest line; partial frame
  task automatic test_most_columns();
    int k;
    write_reg(CFG_FRAME_COLUMNS, '1);
    write_reg(CFG_LINE_LENGTH, CFG_WIDTH'(MIN_SIZE));
    for (k = 0; k < 10 * MIN_SIZE; k++) send_item($urandom_range(0, 99) < 90, 1'b0);
    settle();
  endtask

  // Hold the output off for a long stretch while items keep coming, so the
  // block fills and refuses input
  task automatic test_backpressure();
    write_reg(CFG_FRAME_COLUMNS, CFG_WIDTH'(6));
    write_reg(CFG_LINE_LENGTH, CFG_WIDTH'(8));
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_length = HOLD_CYCLES;
    hold_serial++;
    send_frame(90, 1'b0);
    send_frame(60, 1'b0);
    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Random small sizes, a few frames per setting, varied density, now and
  // then a frame cut short and restarted by the next register write
  task automatic test_random_frames();
    int start, frames, f, density;
    logic [CFG_WIDTH-1:0] cols, line;
    start = items_counted;
    while (items_counted - start < RANDOM_ITEMS) begin
      cols = CFG_WIDTH'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 10));
      line = CFG_WIDTH'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 10));
      case ($urandom_range(0, 2))
        0: begin
          write_reg(CFG_FRAME_COLUMNS, cols);
          write_reg(CFG_LINE_LENGTH, line);
        end
        1: write_reg(CFG_FRAME_COLUMNS, cols);
        default: write_reg(CFG_LINE_LENGTH, line);
      endcase
      // Some settings run with no idling at all on either side
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        case ($urandom_range(0, 4))
          0: density = 0;
          1: density = 40;
          2: density = 75;
          3: density = 90;
          default: density = 100;
        endcase
        send_frame(density, f == frames - 1 && $urandom_range(0, 9) == 0);
      end
      settle();
    end
  endtask

  initial begin
    reg_columns = CFG_WIDTH'(COLUMNS_RESET);
    reg_line    = LINE_REG_WIDTH'(LINE_RESET);
    frame_restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_largest_line();
    test_most_columns();
    test_backpressure();
    test_random_frames();

    // Wait for the last results, then watch for strays
    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d frames over %0d items, %0d results checked",
             frames_seen, items_counted, results_checked);
    $display("sizes 3x3 to 1024-pixel lines and 4096-line frames, stalls on both sides");
    if (mismatch_count == 0 && eroded_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, eroded_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
